FILE: hw/rtl/bpt_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the barometric compensation pipeline.
// No dependencies; every other file in this block depends on this package.
package bpt_pkg;

  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_TEMP_W = 16;
  localparam int OUT_PRES_W = 18;

  localparam int DT_W   = RAW_W + 1;
  localparam int PM_W   = DT_W + COEF_W + 1;
  localparam int DD_W   = 2 * DT_W;
  localparam int Q_W    = 18;
  localparam int O4_W   = 34;
  localparam int S3_W   = 33;
  localparam int T2_W   = 17;
  localparam int TEMP_W = 19;
  localparam int OFF_W  = 36;
  localparam int SENS_W = 35;
  localparam int B_W    = 19;
  localparam int SQ2_W  = 38;
  localparam int TOUT_W = 20;
  localparam int CORR_W = 40;
  localparam int FIN_W  = 41;
  localparam int SPLIT  = 20;
  localparam int HI_W   = FIN_W - SPLIT;
  localparam int PL_W   = RAW_W + SPLIT;
  localparam int PH_W   = RAW_W + 1 + HI_W;
  localparam int TR_W   = 66;
  localparam int Y_W    = 45;
  localparam int X_W    = 46;
  localparam int P_W    = 31;

  localparam int REF_TEMP_SHIFT   = 8;
  localparam int TEMP_SLOPE_SHIFT = 23;
  localparam int OFF_BASE_SHIFT   = 16;
  localparam int OFF_TC_SHIFT     = 7;
  localparam int SENS_BASE_SHIFT  = 15;
  localparam int SENS_TC_SHIFT    = 8;
  localparam int T2_SHIFT         = 31;
  localparam int PROD_SHIFT       = 21;
  localparam int FINAL_SHIFT      = 15;

  localparam int TEMP_BASE     = 2000;
  localparam int COLD_SPAN     = 3500;
  localparam int TEMP_OUT_MIN  = -32768;
  localparam int TEMP_OUT_MAX  = 32767;
  localparam int PRESS_OUT_MAX = 262143;

  typedef struct packed {
    logic [COEF_W-1:0] pressure_sens;
    logic [COEF_W-1:0] pressure_offset;
    logic [COEF_W-1:0] sens_tempco;
    logic [COEF_W-1:0] offset_tempco;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
    logic              second_order_on;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [Q_W-1:0]  q;
    logic signed [O4_W-1:0] o4;
    logic signed [S3_W-1:0] s3;
    logic [T2_W-1:0]        t2;
  } first_t;

  typedef struct packed {
    logic [RAW_W-1:0]             d1;
    logic signed [FIN_W-1:0]      off_f;
    logic signed [FIN_W-1:0]      sens_f;
    logic signed [OUT_TEMP_W-1:0] temp;
    logic                         tsat;
  } corr_t;

  typedef struct packed {
    logic signed [OUT_TEMP_W-1:0] temp_centideg;
    logic [OUT_PRES_W-1:0]        pressure_pa;
    logic                         saturated;
  } result_t;

  // Arithmetic shift right that rounds toward zero.
  function automatic logic signed [TR_W-1:0] trunc_shr(input logic signed [TR_W-1:0] x,
                                                       input int unsigned sh);
    logic signed [TR_W-1:0] bias;
    bias = x[TR_W-1] ? $signed((TR_W'(1) << sh) - TR_W'(1)) : '0;
    return (x + bias) >>> sh;
  endfunction

endpackage

FILE: hw/rtl/bpt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw sample beats and result beats.
// Depends on bpt_pkg for field widths.
interface bpt_sample_if;
  logic                        valid;
  logic                        ready;
  logic [bpt_pkg::RAW_W-1:0]   raw_pressure;
  logic [bpt_pkg::RAW_W-1:0]   raw_temp;

  modport source (output valid, raw_pressure, raw_temp, input ready);
  modport sink   (input valid, raw_pressure, raw_temp, output ready);
endinterface

interface bpt_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpt_pkg::OUT_TEMP_W-1:0] temp_centideg;
  logic [bpt_pkg::OUT_PRES_W-1:0]     pressure_pa;
  logic                               saturated;

  modport source (output valid, temp_centideg, pressure_pa, saturated, input ready);
  modport sink   (input valid, temp_centideg, pressure_pa, saturated, output ready);
endinterface

FILE: hw/rtl/bpt_cfg.sv
`timescale 1ns / 1ps
// Calibration and mode register file, written through a plain write port.
// Depends on bpt_pkg.
module bpt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]    index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0]   wdata,
  output bpt_pkg::cfg_t                    cfg
);
  import bpt_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENS,
    REG_PRESSURE_OFFSET,
    REG_SENS_TEMPCO,
    REG_OFFSET_TEMPCO,
    REG_REF_TEMP,
    REG_TEMP_SLOPE,
    REG_SECOND_ORDER
  } reg_idx_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(index))
        REG_PRESSURE_SENS:   cfg.pressure_sens   <= wdata[COEF_W-1:0];
        REG_PRESSURE_OFFSET: cfg.pressure_offset <= wdata[COEF_W-1:0];
        REG_SENS_TEMPCO:     cfg.sens_tempco     <= wdata[COEF_W-1:0];
        REG_OFFSET_TEMPCO:   cfg.offset_tempco   <= wdata[COEF_W-1:0];
        REG_REF_TEMP:        cfg.ref_temp        <= wdata[COEF_W-1:0];
        REG_TEMP_SLOPE:      cfg.temp_slope      <= wdata[COEF_W-1:0];
        REG_SECOND_ORDER:    cfg.second_order_on <= wdata[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bpt_first.sv
`timescale 1ns / 1ps
// Stages 1-3: temperature difference, calibration products and first-order terms.
// Depends on bpt_pkg.
module bpt_first (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [bpt_pkg::RAW_W-1:0]    d1_in,
  input  logic [bpt_pkg::RAW_W-1:0]    d2_in,
  input  bpt_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output bpt_pkg::first_t              out_data
);
  import bpt_pkg::*;

  logic                    v1, v2;
  logic [RAW_W-1:0]        d1_s1, d1_s2;
  logic signed [DT_W-1:0]  dt_s1;
  logic signed [PM_W-1:0]  p6_s2, p4_s2, p3_s2;
  logic signed [DD_W-1:0]  dd_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_s1 <= d1_in;
      dt_s1 <= $signed({1'b0, d2_in}) -
               $signed(DT_W'(cfg.ref_temp) << REF_TEMP_SHIFT);

      d1_s2 <= d1_s1;
      p6_s2 <= PM_W'(dt_s1) * PM_W'($signed({1'b0, cfg.temp_slope}));
      p4_s2 <= PM_W'(dt_s1) * PM_W'($signed({1'b0, cfg.offset_tempco}));
      p3_s2 <= PM_W'(dt_s1) * PM_W'($signed({1'b0, cfg.sens_tempco}));
      dd_s2 <= DD_W'(dt_s1) * DD_W'(dt_s1);

      out_data.d1 <= d1_s2;
      out_data.q  <= Q_W'(trunc_shr(TR_W'(p6_s2), TEMP_SLOPE_SHIFT));
      out_data.o4 <= O4_W'(trunc_shr(TR_W'(p4_s2), OFF_TC_SHIFT));
      out_data.s3 <= S3_W'(trunc_shr(TR_W'(p3_s2), SENS_TC_SHIFT));
      out_data.t2 <= T2_W'(dd_s2 >>> T2_SHIFT);
    end
  end

endmodule

FILE: hw/rtl/bpt_second.sv
`timescale 1ns / 1ps
// Stages 4-7: offset and sensitivity, second-order correction, temperature clamp.
// Depends on bpt_pkg.
module bpt_second (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  bpt_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  bpt_pkg::first_t   in_data,
  output logic              out_valid,
  output bpt_pkg::corr_t    out_data
);
  import bpt_pkg::*;

  logic                      v4, v5, v6;
  logic [RAW_W-1:0]          d1_s4, d1_s5, d1_s6;
  logic signed [TEMP_W-1:0]  temp_s4;
  logic signed [OFF_W-1:0]   off_s4, off_s5, off_s6;
  logic signed [SENS_W-1:0]  sens_s4, sens_s5, sens_s6;
  logic [T2_W-1:0]           t2_s4;
  logic signed [Q_W-1:0]     q_s4;
  logic signed [B_W-1:0]     b_s4;
  logic                      lo_s4, lo_s5, cold_s4, cold_s5;
  logic signed [TOUT_W-1:0]  tout_s5;
  logic signed [SQ2_W-1:0]   a2_s5, b2_s5;
  logic signed [CORR_W-1:0]  off2_s6, sens2_s6;
  logic signed [OUT_TEMP_W-1:0] temp_s6;
  logic                      tsat_s6;

  logic signed [CORR_W-1:0]  a5, b_x1, b7, b11, off2_next, sens2_next;
  logic signed [OUT_TEMP_W-1:0] temp_next;
  logic                      tsat_next;

  always_comb begin
    a5   = (CORR_W'(a2_s5) <<< 2) + CORR_W'(a2_s5);
    b_x1 = CORR_W'(b2_s5);
    b7   = (b_x1 <<< 3) - b_x1;
    b11  = (b_x1 <<< 3) + (b_x1 <<< 1) + b_x1;
    off2_next  = '0;
    sens2_next = '0;
    if (lo_s5) begin
      off2_next  = (a5 >>> 1) + (cold_s5 ? b7 : '0);
      sens2_next = (a5 >>> 2) + (cold_s5 ? (b11 >>> 1) : '0);
    end
    tsat_next = 1'b1;
    if (tout_s5 < TOUT_W'(TEMP_OUT_MIN)) begin
      temp_next = OUT_TEMP_W'(TEMP_OUT_MIN);
    end else if (tout_s5 > TOUT_W'(TEMP_OUT_MAX)) begin
      temp_next = OUT_TEMP_W'(TEMP_OUT_MAX);
    end else begin
      temp_next = OUT_TEMP_W'(tout_s5);
      tsat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_s4   <= in_data.d1;
      temp_s4 <= TEMP_W'(in_data.q) + TEMP_W'(TEMP_BASE);
      off_s4  <= $signed(OFF_W'(cfg.pressure_offset) << OFF_BASE_SHIFT) + OFF_W'(in_data.o4);
      sens_s4 <= $signed(SENS_W'(cfg.pressure_sens) << SENS_BASE_SHIFT) + SENS_W'(in_data.s3);
      // drop the square term unless the low temperature correction applies
      t2_s4   <= (cfg.second_order_on && in_data.q[Q_W-1]) ? in_data.t2 : '0;
      q_s4    <= in_data.q;
      b_s4    <= B_W'(in_data.q) + B_W'(COLD_SPAN);
      lo_s4   <= cfg.second_order_on && in_data.q[Q_W-1];
      cold_s4 <= in_data.q < -COLD_SPAN;

      d1_s5   <= d1_s4;
      off_s5  <= off_s4;
      sens_s5 <= sens_s4;
      tout_s5 <= TOUT_W'(temp_s4) - $signed(TOUT_W'(t2_s4));
      a2_s5   <= SQ2_W'(q_s4) * SQ2_W'(q_s4);
      b2_s5   <= SQ2_W'(b_s4) * SQ2_W'(b_s4);
      lo_s5   <= lo_s4;
      cold_s5 <= cold_s4;

      d1_s6    <= d1_s5;
      off_s6   <= off_s5;
      sens_s6  <= sens_s5;
      off2_s6  <= off2_next;
      sens2_s6 <= sens2_next;
      temp_s6  <= temp_next;
      tsat_s6  <= tsat_next;

      out_data.d1     <= d1_s6;
      out_data.off_f  <= FIN_W'(off_s6) - FIN_W'(off2_s6);
      out_data.sens_f <= FIN_W'(sens_s6) - FIN_W'(sens2_s6);
      out_data.temp   <= temp_s6;
      out_data.tsat   <= tsat_s6;
    end
  end

endmodule

FILE: hw/rtl/bpt_press.sv
`timescale 1ns / 1ps
// Stages 8-11: split pressure product, scaling, offset removal and output clamp.
// Depends on bpt_pkg.
module bpt_press (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  bpt_pkg::corr_t    in_data,
  output logic              out_valid,
  output bpt_pkg::result_t  out_data
);
  import bpt_pkg::*;

  logic                         v8, v9, v10;
  logic [PL_W-1:0]              pl_s8;
  logic signed [PH_W-1:0]       ph_s8;
  logic signed [TR_W-1:0]       prod_s9;
  logic signed [Y_W-1:0]        y_s10;
  logic signed [X_W-1:0]        x_s11;
  logic signed [FIN_W-1:0]      off_s8, off_s9, off_s10;
  logic signed [OUT_TEMP_W-1:0] temp_s8, temp_s9, temp_s10, temp_s11;
  logic                         tsat_s8, tsat_s9, tsat_s10, tsat_s11;
  logic signed [P_W-1:0]        pf;
  logic                         psat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v8        <= in_valid;
      v9        <= v8;
      v10       <= v9;
      out_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_s8   <= PL_W'(in_data.d1) * PL_W'(in_data.sens_f[SPLIT-1:0]);
      ph_s8   <= PH_W'($signed({1'b0, in_data.d1})) *
                 PH_W'($signed(in_data.sens_f[FIN_W-1:SPLIT]));
      off_s8  <= in_data.off_f;
      temp_s8 <= in_data.temp;
      tsat_s8 <= in_data.tsat;

      prod_s9 <= (TR_W'(ph_s8) <<< SPLIT) + TR_W'($signed({1'b0, pl_s8}));
      off_s9  <= off_s8;
      temp_s9 <= temp_s8;
      tsat_s9 <= tsat_s8;

      y_s10    <= Y_W'(trunc_shr(prod_s9, PROD_SHIFT));
      off_s10  <= off_s9;
      temp_s10 <= temp_s9;
      tsat_s10 <= tsat_s9;

      x_s11    <= X_W'(y_s10) - X_W'(off_s10);
      temp_s11 <= temp_s10;
      tsat_s11 <= tsat_s10;
    end
  end

  always_comb begin
    pf   = P_W'(trunc_shr(TR_W'(x_s11), FINAL_SHIFT));
    psat = 1'b1;
    if (pf < 0) begin
      out_data.pressure_pa = '0;
    end else if (pf > P_W'(PRESS_OUT_MAX)) begin
      out_data.pressure_pa = OUT_PRES_W'(PRESS_OUT_MAX);
    end else begin
      out_data.pressure_pa = $unsigned(OUT_PRES_W'(pf));
      psat = 1'b0;
    end
    out_data.temp_centideg = temp_s11;
    out_data.saturated     = tsat_s11 | psat;
  end

endmodule

FILE: hw/rtl/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// Barometric pressure and temperature compensation, fully pipelined. Takes one
// sample beat (raw pressure and raw temperature) per clock and returns one result
// beat per sample: temperature in 0.01 degree and pressure in pascal, both
// saturated, with a flag when either is clamped. Results leave in sample order; a
// result beat passes through the eleven pipeline stages around the calibration
// multipliers, the second-order squares and the split 24 x 41 bit pressure product,
// the first of which loads on the edge that accepts its sample, and then through
// the output register. An output register and a one-entry skid buffer let the
// pipeline take a sample per clock while a finished result waits; the input stalls
// only when both are full. Write the calibration and mode registers only while no
// sample is in flight.
// Depends on bpt_pkg, bpt_if, bpt_cfg, bpt_first, bpt_second and bpt_press.
module baro_pressure_temp_compensation (
  input  logic                            clk,
  input  logic                            rst,
  bpt_sample_if.sink                      sample,
  bpt_result_if.source                    result,
  input  logic                            cfg_wr_en,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bpt_pkg::*;

  cfg_t    cfg;
  logic    adv;
  logic    first_valid, corr_valid, fin_valid;
  first_t  first_data;
  corr_t   corr_data;
  result_t fin_data;
  logic    res_valid, skid_valid;
  result_t res_data, skid_data;
  logic    hold;

  bpt_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  bpt_first u_first (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .d1_in     (sample.raw_pressure),
    .d2_in     (sample.raw_temp),
    .cfg       (cfg),
    .out_valid (first_valid),
    .out_data  (first_data)
  );

  bpt_second u_second (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (first_valid),
    .in_data   (first_data),
    .out_valid (corr_valid),
    .out_data  (corr_data)
  );

  bpt_press u_press (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (corr_valid),
    .in_data   (corr_data),
    .out_valid (fin_valid),
    .out_data  (fin_data)
  );

  // Advance the pipeline whenever the skid slot is free.
  assign adv          = !skid_valid;
  assign sample.ready = adv;
  assign hold         = res_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (hold) begin
      if (fin_valid && adv) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      res_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      res_valid <= fin_valid && adv;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (fin_valid && adv) begin
        skid_data <= fin_data;
      end
    end else if (skid_valid) begin
      res_data <= skid_data;
    end else begin
      res_data <= fin_data;
    end
  end

  assign result.valid         = res_valid;
  assign result.temp_centideg = res_data.temp_centideg;
  assign result.pressure_pa   = res_data.pressure_pa;
  assign result.saturated     = res_data.saturated;

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && !result.ready))
    else $error("skid filled without an output stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result.ready |=> res_valid && !skid_valid)
    else $error("skid beat not moved to the output");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.pressure_pa != '0 &&
    res_data.pressure_pa != OUT_PRES_W'(PRESS_OUT_MAX) &&
    res_data.temp_centideg != OUT_TEMP_W'(TEMP_OUT_MIN) &&
    res_data.temp_centideg != OUT_TEMP_W'(TEMP_OUT_MAX) |-> !res_data.saturated)
    else $error("saturation flag set on an unclamped result");

endmodule
